>>> rtl/mpbm_pkg.sv
// Package for the multi-pattern byte matcher: sizes, operation and status codes,
// and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package mpbm_pkg;

	localparam int MAX_STATES      = 256;
	localparam int MAX_PATTERN_LEN = 32;
	localparam int MAX_RESULTS     = 32;
	localparam int STATE_W         = $clog2(MAX_STATES);
	localparam int GOTO_AW         = STATE_W + 8;
	localparam int LEN_W           = 6;
	localparam int POS_W           = 16;
	localparam int ID_W            = 6;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_BUILD  = 2'd1,
		OP_SEARCH = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_MATCH    = 2'd0,
		STS_DONE     = 2'd1,
		STS_FULL     = 2'd2,
		STS_TOO_LONG = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE,
		S_ADD_RD, S_ADD_EV, S_ADD_PAT,
		S_BR0, S_BR1, S_BQ0, S_BQ1, S_BQ2, S_BC0, S_BC1, S_BF0, S_BF1, S_BF2,
		S_SS0, S_SS1, S_SS2, S_SO0, S_SO1,
		S_FIN
	} state_t;

endpackage

>>> rtl/multi_pattern_byte_matcher_core.sv
// Multi-pattern byte matcher top level: trie memories and the sequencer around them.
// Depends on mpbm_pkg.
`timescale 1ns / 1ps

// One item at a time. An add, a search and a build each run as a sequence of states;
// a search follows failure links and then the suffix chain, and a build walks every
// symbol of every node and follows failure links. Every goto lookup goes through the
// single read port of the goto memory, and a stalled result holds the sequencer. After
// reset, and on a clear item, the goto memory is swept one entry a cycle, all 65536
// entries, during which no item is taken.
module multi_pattern_byte_matcher_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  op,
	input  logic [7:0]                  symbol,
	input  logic                        last,
	input  logic [mpbm_pkg::ID_W-1:0]   pattern_id,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [mpbm_pkg::ID_W-1:0]   match_id,
	output logic [mpbm_pkg::POS_W-1:0]  first_pos,
	output logic [mpbm_pkg::POS_W-1:0]  end_pos,
	output logic                        final_res
);
	import mpbm_pkg::*;

	state_t state_q, state_n;

	// Memories and their registered read data.
	logic [STATE_W-1:0] goto_mem [1<<GOTO_AW];
	logic [STATE_W-1:0] fail_mem [MAX_STATES];
	logic [ID_W:0]      pat_mem  [MAX_STATES];
	logic [LEN_W-1:0]   dep_mem  [MAX_STATES];
	logic [STATE_W-1:0] que_mem  [MAX_STATES];

	logic [STATE_W-1:0] g_rd_q, f_rd_q, q_rd_q;
	logic [ID_W:0]      p_rd_q;
	logic [LEN_W-1:0]   d_rd_q;

	logic [GOTO_AW-1:0] g_raddr, g_waddr;
	logic [STATE_W-1:0] g_wdata, n_raddr, n_waddr, f_wdata, q_wdata;
	logic               g_we, f_we, p_we, d_we, q_we;
	logic [ID_W:0]      p_wdata;
	logic [LEN_W-1:0]   d_wdata;

	// Control and datapath registers.
	logic [GOTO_AW-1:0] clr_cnt_q;
	logic               clr_op_q;
	logic [STATE_W:0]   free_q;
	logic [STATE_W-1:0] cur_q;
	logic [LEN_W-1:0]   len_q;
	logic [1:0]         drop_q;
	logic [STATE_W-1:0] sstate_q;
	logic [POS_W-1:0]   pos_q;
	logic [7:0]         sym_q, c_q;
	logic               last_q;
	logic [ID_W-1:0]    id_q;
	logic [STATE_W:0]   head_q, tail_q;
	logic [STATE_W-1:0] r_q, fr_q, f_q, s_q, t_q, nxt_q;
	logic [5:0]         k_q;
	logic               pend_v_q;
	logic [1:0]         pend_sts_q;
	logic [ID_W-1:0]    pend_id_q;
	logic [POS_W-1:0]   pend_start_q, pend_end_q;
	logic               out_valid_q;
	logic [1:0]         out_sts_q;
	logic [ID_W-1:0]    out_id_q;
	logic [POS_W-1:0]   out_start_q, out_end_q;
	logic               out_fin_q;

	logic slot_free, accept;
	logic add_alloc, add_adv;
	logic [1:0] add_drop;
	logic [STATE_W-1:0] add_nxt;
	logic so_match;
	logic [POS_W:0] pos_p1, start_w;
	logic emit_pend, emit_fin;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;

	// Add decision on the goto entry read for the insertion cursor.
	always_comb begin
		add_drop  = drop_q;
		add_alloc = 1'b0;
		add_adv   = 1'b0;
		if (drop_q == 2'd0) begin
			if (len_q >= LEN_W'(MAX_PATTERN_LEN)) begin
				add_drop = STS_TOO_LONG;
			end else if (g_rd_q == '0) begin
				if (free_q >= (STATE_W+1)'(MAX_STATES)) begin
					add_drop = STS_FULL;
				end else begin
					add_alloc = 1'b1;
					add_adv   = 1'b1;
				end
			end else begin
				add_adv = 1'b1;
			end
		end
		add_nxt = add_alloc ? free_q[STATE_W-1:0] : g_rd_q;
	end

	assign so_match = p_rd_q[ID_W];
	assign pos_p1   = {1'b0, pos_q} + 1'b1;
	assign start_w  = (d_rd_q != '0 && pos_p1 >= {{(POS_W+1-LEN_W){1'b0}}, d_rd_q})
	                  ? pos_p1 - {{(POS_W+1-LEN_W){1'b0}}, d_rd_q} : '0;

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_CLR:     if (clr_cnt_q == '1) state_n = clr_op_q ? S_FIN : S_IDLE;
			S_IDLE: begin
				if (accept) begin
					unique case (op_t'(op))
						OP_ADD:    state_n = S_ADD_RD;
						OP_BUILD:  state_n = S_BR0;
						OP_SEARCH: state_n = S_SS0;
						OP_CLEAR:  state_n = S_CLR;
					endcase
				end
			end
			S_ADD_RD:  state_n = S_ADD_EV;
			S_ADD_EV:  state_n = (last_q && add_adv && !add_alloc) ? S_ADD_PAT : S_FIN;
			S_ADD_PAT: state_n = S_FIN;
			S_BR0:     state_n = S_BR1;
			S_BR1:     state_n = (c_q == 8'hFF) ? S_BQ0 : S_BR0;
			S_BQ0:     state_n = (head_q == tail_q) ? S_FIN : S_BQ1;
			S_BQ1:     state_n = S_BQ2;
			S_BQ2:     state_n = S_BC0;
			S_BC0:     state_n = S_BC1;
			S_BC1: begin
				if (g_rd_q != '0) state_n = S_BF0;
				else state_n = (c_q == 8'hFF) ? S_BQ0 : S_BC0;
			end
			S_BF0:     state_n = S_BF1;
			S_BF1: begin
				if (f_q == '0 || g_rd_q != '0) state_n = (c_q == 8'hFF) ? S_BQ0 : S_BC0;
				else state_n = S_BF2;
			end
			S_BF2:     state_n = S_BF0;
			S_SS0:     state_n = S_SS1;
			S_SS1:     state_n = (s_q == '0 || g_rd_q != '0) ? S_SO0 : S_SS2;
			S_SS2:     state_n = S_SS0;
			S_SO0:     state_n = (t_q == '0 || k_q == 6'(MAX_RESULTS)) ? S_FIN : S_SO1;
			S_SO1:     if (!(so_match && pend_v_q && !slot_free)) state_n = S_SO0;
			S_FIN:     if (slot_free) state_n = S_IDLE;
			default:   state_n = S_IDLE;
		endcase
	end

	// Memory addressing and write controls.
	always_comb begin
		g_raddr = '0;
		g_we    = 1'b0;
		g_waddr = {cur_q, sym_q};
		g_wdata = free_q[STATE_W-1:0];
		n_raddr = t_q;
		n_waddr = free_q[STATE_W-1:0];
		f_we    = 1'b0;
		f_wdata = '0;
		p_we    = 1'b0;
		p_wdata = {1'b1, id_q};
		d_we    = 1'b0;
		d_wdata = len_q + 1'b1;
		q_we    = 1'b0;
		q_wdata = g_rd_q;
		emit_pend = 1'b0;
		emit_fin  = 1'b0;
		unique case (state_q)
			S_CLR: begin
				g_we    = 1'b1;
				g_waddr = clr_cnt_q;
				g_wdata = '0;
			end
			S_ADD_RD: g_raddr = {cur_q, sym_q};
			S_ADD_EV: begin
				n_raddr = g_rd_q;
				if (add_alloc) begin
					g_we    = 1'b1;
					f_we    = 1'b1;
					p_we    = 1'b1;
					p_wdata = last_q ? {1'b1, id_q} : '0;
					d_we    = 1'b1;
				end
			end
			S_ADD_PAT: begin
				n_waddr = nxt_q;
				p_we    = !p_rd_q[ID_W];
			end
			S_BR0: g_raddr = {{STATE_W{1'b0}}, c_q};
			S_BR1: begin
				n_waddr = g_rd_q;
				f_we    = (g_rd_q != '0);
				q_we    = (g_rd_q != '0);
			end
			S_BQ1: n_raddr = q_rd_q;
			S_BC0: g_raddr = {r_q, c_q};
			S_BC1: q_we = (g_rd_q != '0);
			S_BF0: g_raddr = {f_q, c_q};
			S_BF1: begin
				n_raddr = f_q;
				n_waddr = s_q;
				f_we    = (f_q == '0 || g_rd_q != '0);
				f_wdata = (g_rd_q != s_q) ? g_rd_q : '0;
			end
			S_SS0: g_raddr = {s_q, sym_q};
			S_SS1: n_raddr = s_q;
			S_SO1: emit_pend = so_match && pend_v_q && slot_free;
			S_FIN: emit_fin = slot_free;
			default: ;
		endcase
	end

	// Memories.
	always_ff @(posedge clk) begin
		if (g_we) goto_mem[g_waddr] <= g_wdata;
		g_rd_q <= goto_mem[g_raddr];
	end

	always_ff @(posedge clk) begin
		if (f_we) fail_mem[n_waddr] <= f_wdata;
		if (p_we) pat_mem[n_waddr]  <= p_wdata;
		if (d_we) dep_mem[n_waddr]  <= d_wdata;
		if (q_we) que_mem[tail_q[STATE_W-1:0]] <= q_wdata;
		f_rd_q <= fail_mem[n_raddr];
		p_rd_q <= pat_mem[n_raddr];
		d_rd_q <= dep_mem[n_raddr];
		q_rd_q <= que_mem[head_q[STATE_W-1:0]];
	end

	// Sequencer registers and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_cnt_q   <= '0;
			clr_op_q    <= 1'b0;
			free_q      <= (STATE_W+1)'(1);
			cur_q       <= '0;
			len_q       <= '0;
			drop_q      <= '0;
			sstate_q    <= '0;
			pos_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			k_q         <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (emit_pend || emit_fin) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLR: clr_cnt_q <= clr_cnt_q + 1'b1;
				S_IDLE: begin
					if (accept) begin
						sym_q        <= symbol;
						last_q       <= last;
						id_q         <= pattern_id;
						pend_v_q     <= 1'b0;
						pend_sts_q   <= STS_DONE;
						pend_id_q    <= '0;
						pend_start_q <= '0;
						pend_end_q   <= '0;
						c_q          <= '0;
						head_q       <= '0;
						tail_q       <= '0;
						s_q          <= sstate_q;
						if (op_t'(op) == OP_CLEAR) begin
							clr_cnt_q <= '0;
							clr_op_q  <= 1'b1;
							free_q    <= (STATE_W+1)'(1);
							cur_q     <= '0;
							len_q     <= '0;
							drop_q    <= '0;
							sstate_q  <= '0;
							pos_q     <= '0;
						end
					end
				end
				S_ADD_EV: begin
					nxt_q      <= g_rd_q;
					drop_q     <= last_q ? 2'd0 : add_drop;
					pend_sts_q <= (add_drop != 2'd0) ? add_drop : STS_DONE;
					if (add_alloc) free_q <= free_q + 1'b1;
					if (last_q) begin
						cur_q <= '0;
						len_q <= '0;
					end else if (add_adv) begin
						cur_q <= add_nxt;
						len_q <= len_q + 1'b1;
					end
				end
				S_BR1: begin
					c_q <= c_q + 1'b1;
					if (g_rd_q != '0) tail_q <= tail_q + 1'b1;
				end
				S_BQ1: begin
					r_q    <= q_rd_q;
					head_q <= head_q + 1'b1;
				end
				S_BQ2: begin
					fr_q <= f_rd_q;
					c_q  <= '0;
				end
				S_BC1: begin
					if (g_rd_q != '0) begin
						tail_q <= tail_q + 1'b1;
						s_q    <= g_rd_q;
						f_q    <= fr_q;
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				S_BF1: if (f_q == '0 || g_rd_q != '0) c_q <= c_q + 1'b1;
				S_BF2: f_q <= f_rd_q;
				S_SS1: begin
					if (s_q == '0 || g_rd_q != '0) begin
						sstate_q <= g_rd_q;
						t_q      <= g_rd_q;
						k_q      <= '0;
					end
				end
				S_SS2: s_q <= f_rd_q;
				S_SO0: begin
					if (t_q == '0 || k_q == 6'(MAX_RESULTS)) begin
						if (last_q) begin
							sstate_q <= '0;
							pos_q    <= '0;
						end else if (pos_q != '1) begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				S_SO1: begin
					if (!(so_match && pend_v_q && !slot_free)) begin
						t_q <= f_rd_q;
						if (so_match) begin
							k_q          <= k_q + 1'b1;
							pend_v_q     <= 1'b1;
							pend_sts_q   <= STS_MATCH;
							pend_id_q    <= p_rd_q[ID_W-1:0];
							pend_start_q <= start_w[POS_W-1:0];
							pend_end_q   <= pos_q;
						end
					end
				end
				S_FIN: if (slot_free) clr_op_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// Output payload; a held result keeps its value while stalled.
	always_ff @(posedge clk) begin
		if (emit_pend || emit_fin) begin
			out_sts_q   <= pend_sts_q;
			out_id_q    <= pend_id_q;
			out_start_q <= pend_start_q;
			out_end_q   <= pend_end_q;
			out_fin_q   <= emit_fin;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_sts_q;
	assign match_id  = out_id_q;
	assign first_pos = out_start_q;
	assign end_pos   = out_end_q;
	assign final_res = out_fin_q;

endmodule

>>> rtl/mpbm_checker.sv
// Port-level checks on the matcher's result channel, bound to the top level.
// Depends on mpbm_pkg.
`timescale 1ns / 1ps

module mpbm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [1:0]                  status,
	input logic [mpbm_pkg::ID_W-1:0]   match_id,
	input logic [mpbm_pkg::POS_W-1:0]  first_pos,
	input logic [mpbm_pkg::POS_W-1:0]  end_pos,
	input logic                        final_res
);
	import mpbm_pkg::*;

	// A result the receiver has not taken stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// Anything but a match closes the item's results.
	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STS_MATCH |-> final_res)
		else $error("non-match result not marked final");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STS_MATCH |-> match_id == '0 && first_pos == '0 && end_pos == '0)
		else $error("non-match result carries match fields");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STS_MATCH |-> first_pos <= end_pos)
		else $error("match starts after it ends");

endmodule

bind multi_pattern_byte_matcher_core mpbm_checker u_mpbm_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.status(status), .match_id(match_id), .first_pos(first_pos), .end_pos(end_pos),
	.final_res(final_res)
);

>>> sim/tb.sv
// Self-checking testbench for multi_pattern_byte_matcher_core: table of directed items, then
// structured random add/build/search rounds checked against an in-bench trie predictor.
// Depends on mpbm_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
	import mpbm_pkg::*;

	typedef struct packed {
		status_t          sts;
		logic [ID_W-1:0]  id;
		logic [POS_W-1:0] spos;
		logic [POS_W-1:0] epos;
		logic             fin;
	} match_res_t;

	typedef struct {
		op_t        op;
		logic [7:0] sym;
		logic       lst;
		logic [5:0] pid;
		logic       typed;
		status_t    sts;
	} dir_row_t;

	localparam int WATCHDOG_LIMIT = 1000000;
	localparam int NDIR = 27;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [1:0]       op;
	logic [7:0]       symbol;
	logic             last;
	logic [ID_W-1:0]  pattern_id;
	logic             out_valid;
	logic             out_stall;
	logic [1:0]       status;
	logic [ID_W-1:0]  match_id;
	logic [POS_W-1:0] first_pos;
	logic [POS_W-1:0] end_pos;
	logic             final_res;

	// Typed expectation travels with the item so it is sampled at the same edge.
	logic    row_typed;
	status_t row_sts;

	// Predictor state.
	logic [7:0] goto_mem [0:65535];
	logic [7:0] fail_mem [0:255];
	logic [6:0] tag_mem [0:255];
	logic [5:0] depth_mem [0:255];
	int         next_free;
	logic [7:0] add_cursor;
	int         add_len;
	logic [1:0] add_drop;
	logic [7:0] scan_state;
	int         scan_pos;

	match_res_t pending_res[$];
	int         n_errors;
	int         idle_pct;
	int         quiet_cycles;
	int         hold_req;
	int         hold_left;
	int         stall_cycles;

	dir_row_t dir_tab [0:NDIR-1] = '{
		'{OP_SEARCH, 8'h78, 1'b1, 6'd0, 1'b1, STS_DONE},
		'{OP_ADD, "h", 1'b0, 6'd0, 1'b1, STS_DONE},
		'{OP_ADD, "e", 1'b1, 6'd63, 1'b1, STS_DONE},
		'{OP_ADD, "s", 1'b0, 6'd0, 1'b1, STS_DONE},
		'{OP_ADD, "h", 1'b0, 6'd0, 1'b1, STS_DONE},
		'{OP_ADD, "e", 1'b1, 6'd21, 1'b1, STS_DONE},
		'{OP_ADD, "h", 1'b0, 6'd0, 1'b1, STS_DONE},
		'{OP_ADD, "i", 1'b0, 6'd0, 1'b1, STS_DONE},
		'{OP_ADD, "s", 1'b1, 6'd42, 1'b1, STS_DONE},
		'{OP_ADD, "h", 1'b0, 6'd0, 1'b1, STS_DONE},
		'{OP_ADD, "e", 1'b0, 6'd0, 1'b1, STS_DONE},
		'{OP_ADD, "r", 1'b0, 6'd0, 1'b1, STS_DONE},
		'{OP_ADD, "s", 1'b1, 6'd5, 1'b1, STS_DONE},
		'{OP_BUILD, 8'h00, 1'b0, 6'd0, 1'b1, STS_DONE},
		'{OP_SEARCH, "u", 1'b0, 6'd0, 1'b0, STS_DONE},
		'{OP_SEARCH, "s", 1'b0, 6'd0, 1'b0, STS_DONE},
		'{OP_SEARCH, "h", 1'b0, 6'd0, 1'b0, STS_DONE},
		'{OP_SEARCH, "e", 1'b0, 6'd0, 1'b0, STS_DONE},
		'{OP_SEARCH, "r", 1'b0, 6'd0, 1'b0, STS_DONE},
		'{OP_SEARCH, "s", 1'b1, 6'd0, 1'b0, STS_DONE},
		'{OP_ADD, 8'h00, 1'b0, 6'd0, 1'b1, STS_DONE},
		'{OP_ADD, 8'hFF, 1'b1, 6'd1, 1'b1, STS_DONE},
		'{OP_SEARCH, 8'h00, 1'b0, 6'd0, 1'b0, STS_DONE},
		'{OP_SEARCH, 8'hFF, 1'b1, 6'd0, 1'b0, STS_DONE},
		'{OP_ADD, "h", 1'b0, 6'd7, 1'b1, STS_DONE},
		'{OP_ADD, "e", 1'b1, 6'd7, 1'b1, STS_DONE},
		'{OP_CLEAR, 8'h00, 1'b0, 6'd0, 1'b1, STS_DONE}
	};

	multi_pattern_byte_matcher_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.symbol     (symbol),
		.last       (last),
		.pattern_id (pattern_id),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.match_id   (match_id),
		.first_pos  (first_pos),
		.end_pos    (end_pos),
		.final_res  (final_res)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void trie_wipe();
		for (int i = 0; i < 65536; i++) goto_mem[i] = '0;
		for (int i = 0; i < 256; i++) begin
			fail_mem[i] = '0;
			tag_mem[i] = '0;
			depth_mem[i] = '0;
		end
		next_free = 1;
		add_cursor = '0;
		add_len = 0;
		add_drop = '0;
		scan_state = '0;
		scan_pos = 0;
	endfunction

	function automatic status_t trie_add(logic [7:0] c, logic lst, logic [5:0] pid);
		logic [7:0] nxt;
		status_t    res;
		res = STS_DONE;
		if (add_drop == 0) begin
			if (add_len >= MAX_PATTERN_LEN) begin
				add_drop = STS_TOO_LONG;
			end else begin
				nxt = goto_mem[{add_cursor, c}];
				if (nxt == 0) begin
					if (next_free >= MAX_STATES) begin
						add_drop = STS_FULL;
					end else begin
						nxt = next_free[7:0];
						next_free++;
						goto_mem[{add_cursor, c}] = nxt;
						fail_mem[nxt] = '0;
						tag_mem[nxt] = '0;
						depth_mem[nxt] = 6'(add_len + 1);
					end
				end
				if (add_drop == 0) begin
					add_cursor = nxt;
					add_len++;
					if (lst && !tag_mem[nxt][6])
						tag_mem[nxt] = {1'b1, pid};
				end
			end
		end
		if (add_drop != 0) res = status_t'(add_drop);
		if (lst) begin
			add_cursor = '0;
			add_len = 0;
			add_drop = '0;
		end
		return res;
	endfunction

	function automatic void trie_build();
		logic [7:0] bfs [0:255];
		int         head, tail, steps;
		logic [7:0] r, s, f, g;
		head = 0;
		tail = 0;
		for (int c = 0; c < 256; c++) begin
			s = goto_mem[{8'd0, c[7:0]}];
			if (s != 0 && tail < MAX_STATES) begin
				fail_mem[s] = '0;
				bfs[tail] = s;
				tail++;
			end
		end
		while (head < tail) begin
			r = bfs[head];
			head++;
			for (int c = 0; c < 256; c++) begin
				s = goto_mem[{r, c[7:0]}];
				if (s != 0) begin
					if (tail < MAX_STATES) begin
						bfs[tail] = s;
						tail++;
					end
					f = fail_mem[r];
					steps = 0;
					while (f != 0 && goto_mem[{f, c[7:0]}] == 0 && steps < MAX_STATES) begin
						f = fail_mem[f];
						steps++;
					end
					g = goto_mem[{f, c[7:0]}];
					fail_mem[s] = (g != s) ? g : 8'd0;
				end
			end
		end
	endfunction

	function automatic void scan_byte(logic [7:0] c, logic lst);
		logic [7:0] s, t;
		int         steps, k, len, first;
		match_res_t m;
		s = scan_state;
		steps = 0;
		while (s != 0 && goto_mem[{s, c}] == 0 && steps < MAX_STATES) begin
			s = fail_mem[s];
			steps++;
		end
		s = goto_mem[{s, c}];
		scan_state = s;
		t = s;
		steps = 0;
		k = 0;
		while (t != 0 && k < MAX_RESULTS && steps < MAX_STATES) begin
			if (tag_mem[t][6]) begin
				len = depth_mem[t];
				first = (len != 0 && scan_pos + 1 >= len) ? scan_pos + 1 - len : 0;
				m = '{STS_MATCH, tag_mem[t][5:0], first[15:0], scan_pos[15:0], 1'b0};
				pending_res.push_back(m);
				k++;
			end
			t = fail_mem[t];
			steps++;
		end
		if (k == 0) pending_res.push_back(match_res_t'{STS_DONE, '0, '0, '0, 1'b1});
		else pending_res[pending_res.size() - 1].fin = 1'b1;
		if (lst) begin
			scan_state = '0;
			scan_pos = 0;
		end else if (scan_pos < 65535) begin
			scan_pos++;
		end
	endfunction

	function automatic void predict_item(logic [1:0] o, logic [7:0] c, logic lst,
			logic [5:0] pid, logic typed, status_t tsts);
		status_t res;
		int      n_before;
		res = STS_DONE;
		n_before = pending_res.size();
		case (op_t'(o))
			OP_ADD: res = trie_add(c, lst, pid);
			OP_BUILD: trie_build();
			OP_CLEAR: trie_wipe();
			default: scan_byte(c, lst);
		endcase
		// A typed row stands in for whatever the predictor queued for it.
		if (typed) begin
			while (pending_res.size() > n_before) void'(pending_res.pop_back());
			pending_res.push_back(match_res_t'{tsts, '0, '0, '0, 1'b1});
		end else if (op_t'(o) != OP_SEARCH) begin
			pending_res.push_back(match_res_t'{res, '0, '0, '0, 1'b1});
		end
	endfunction

	// Scoreboard and watchdog.
	always @(posedge clk) begin
		match_res_t want, got;
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_item(op, symbol, last, pattern_id, row_typed, row_sts);
			if (out_valid && !out_stall) begin
				got = '{status_t'(status), match_id, first_pos, end_pos, final_res};
				if (pending_res.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("unexpected result: sts=%0d id=%0d start=%0d end=%0d fin=%0d",
							got.sts, got.id, got.spos, got.epos, got.fin);
				end else begin
					want = pending_res.pop_front();
					if (got.sts != want.sts || got.id != want.id || got.spos != want.spos ||
							got.epos != want.epos || got.fin != want.fin) begin
						n_errors++;
						if (n_errors <= 10)
							$display("mismatch: exp sts=%0d id=%0d start=%0d end=%0d fin=%0d, got sts=%0d id=%0d start=%0d end=%0d fin=%0d",
								want.sts, want.id, want.spos, want.epos, want.fin,
								got.sts, got.id, got.spos, got.epos, got.fin);
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= WATCHDOG_LIMIT) begin
					$display("[multi_pattern_byte_matcher_core] ERROR");
					$finish;
				end
			end
		end
	end

	// Receiver: random back-pressure, with one long hold-off on request.
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_req = 0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	task automatic send_row(logic [1:0] o, logic [7:0] c, logic lst, logic [5:0] pid,
			logic typed, status_t tsts);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		symbol <= c;
		last <= lst;
		pattern_id <= pid;
		row_typed <= typed;
		row_sts <= tsts;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send(op_t o, logic [7:0] c, logic lst, logic [5:0] pid);
		send_row(o, c, lst, pid, 1'b0, STS_DONE);
	endtask

	// Random pattern or text over a small per-round alphabet, so matches are frequent.
	task automatic send_string(op_t o, logic [7:0] alpha [4], int len, logic [5:0] pid);
		for (int i = 0; i < len; i++) begin
			if (o == OP_SEARCH && $urandom_range(19) == 0)
				send(op_t'($urandom_range(2)), 8'($urandom), 1'($urandom), 6'($urandom));
			send(o, alpha[$urandom_range(3)], i == len - 1, pid);
		end
	endtask

	initial begin
		logic [7:0] alpha [4];
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_ADD;
		symbol = '0;
		last = 1'b0;
		pattern_id = '0;
		row_typed = 1'b0;
		row_sts = STS_DONE;
		n_errors = 0;
		idle_pct = 18;
		hold_req = 0;
		hold_left = 0;
		stall_cycles = 0;
		trie_wipe();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i])
			send_row(dir_tab[i].op, dir_tab[i].sym, dir_tab[i].lst, dir_tab[i].pid,
				dir_tab[i].typed, dir_tab[i].sts);

		for (int rnd = 0; rnd < 8; rnd++) begin
			idle_pct = (rnd == 5 || rnd == 6) ? 0 : 18;
			foreach (alpha[j]) alpha[j] = 8'($urandom);
			for (int p = 0; p < $urandom_range(5, 2); p++)
				send_string(OP_ADD, alpha, $urandom_range(4, 1), 6'($urandom));
			if (rnd == 2)
				send_string(OP_ADD, alpha, 35, 6'($urandom));
			if ($urandom_range(3) != 0)
				send(OP_BUILD, 8'($urandom), 1'($urandom), 6'($urandom));
			if (rnd == 4) hold_req = 1;
			for (int t = 0; t < 3; t++)
				send_string(OP_SEARCH, alpha, $urandom_range(12, 3), '0);
		end

		// Fill the state table, then overflow it.
		idle_pct = 18;
		while (next_free < MAX_STATES) begin
			send(OP_ADD, 8'($urandom), 1'b0, '0);
			for (int i = 1; i < 32; i++)
				send(OP_ADD, 8'($urandom), i == 31, 6'($urandom));
		end
		for (int i = 0; i < 3; i++)
			send(OP_ADD, 8'($urandom), i == 2, 6'($urandom));
		send_string(OP_SEARCH, alpha, 10, '0);
		send(OP_CLEAR, 8'($urandom), 1'($urandom), 6'($urandom));
		send_string(OP_ADD, alpha, 3, 6'($urandom));
		send(OP_BUILD, '0, 1'b0, '0);
		send_string(OP_SEARCH, alpha, 12, '0);
		in_valid <= 1'b0;

		while (pending_res.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (n_errors == 0)
			$display("[multi_pattern_byte_matcher_core] OK");
		else
			$display("[multi_pattern_byte_matcher_core] ERROR");
		$finish;
	end

endmodule
